// ===== hdl/fwst_pkg.sv =====
// Shared types, constants and codes of the flit width converter.
`default_nettype none
package fwst_pkg;

  localparam int unsigned NumChannels    = 16;
  localparam int unsigned RatioFifoDepth = 4;
  localparam int unsigned MaxParts       = 16;

  // Flit kind codes
  localparam logic [2:0] KindHead     = 3'd0;
  localparam logic [2:0] KindBody     = 3'd1;
  localparam logic [2:0] KindTail     = 3'd2;
  localparam logic [2:0] KindHeadTail = 3'd3;
  localparam logic [2:0] KindCredit   = 3'd4;

  // Result error codes
  localparam logic [1:0] ErrOk      = 2'd0;
  localparam logic [1:0] ErrEmpty   = 2'd1;
  localparam logic [1:0] ErrFull    = 2'd2;
  localparam logic [1:0] ErrClamped = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegCurW   = 2'd1;
  localparam logic [1:0] RegTgtW   = 2'd2;

  // Input item fields
  typedef struct packed {
    logic [7:0]  ratio_value;
    logic [11:0] message_bytes;
    logic [7:0]  flit_index;
    logic [3:0]  channel;
    logic [2:0]  flit_kind;
    logic        operation;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic       last;
    logic [1:0] error_code;
    logic [7:0] notice_count;
    logic       notice_valid;
    logic [7:0] merged_count;
    logic [4:0] part_total;
    logic [3:0] part_number;
    logic [2:0] out_kind;
    logic [3:0] out_channel;
    logic       flit_valid;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture input item and read channel state
    logic prep;     // compute quotient setup
    logic div_step; // one divider iteration
    logic finish;   // decide result, write back state
    logic emit;     // present part; advance on take
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic last_part;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/flit_width_serdes_tracker_top.sv =====
// Top level of the per virtual channel flit width converter.
// An item passes through a setup step, 17 bit-serial divide steps by the target width
// and a done check, a decision step, its result parts and a return to idle before
// the next item is taken; a stalled result holds the block until it is taken.
// The block handles one item at a time; configuration is taken any cycle and
// should be written only while no item is in flight.
`default_nettype none
module flit_width_serdes_tracker_top #(
  parameter int unsigned NumChannels    = fwst_pkg::NumChannels,
  parameter int unsigned RatioFifoDepth = fwst_pkg::RatioFifoDepth,
  parameter int unsigned MaxParts       = fwst_pkg::MaxParts
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // operation, flit_kind, channel, flit_index, message_bytes, ratio_value
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // flit_valid, out_channel, out_kind, part_number, part_total, merged_count,
  // notice_valid, notice_count, error_code
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);

  fwst_pkg::dp_cmd_t   cmd;
  fwst_pkg::dp_sts_t   sts;
  fwst_pkg::out_item_t res;
  fwst_pkg::in_item_t  item;
  logic       en_q;
  logic [8:0] cw_q, tw_q;
  logic       in_fire;

  assign item    = fwst_pkg::in_item_t'(s_axis_tdata[35:0]);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1; cw_q <= 9'd16; tw_q <= 9'd32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fwst_pkg::RegEnable: en_q <= cfg_data_i[0];
        fwst_pkg::RegCurW:   cw_q <= cfg_data_i;
        fwst_pkg::RegTgtW:   tw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fwst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  fwst_dp #(
    .NumChannels(NumChannels), .RatioFifoDepth(RatioFifoDepth), .MaxParts(MaxParts)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(item), .en_i(en_q),
    .cur_w_i(cw_q), .tgt_w_i(tw_q), .sts_o(sts), .res_o(res)
  );

  assign m_axis_tdata = {4'd0, res[35:0]};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// ===== hdl/fwst_ctrl.sv =====
// Controller state machine sequencing the converter datapath.
`default_nettype none
module fwst_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_fire_i,
  input  wire logic               out_ready_i,
  input  wire fwst_pkg::dp_sts_t  sts_i,
  output fwst_pkg::dp_cmd_t       cmd_o,
  output logic                    in_ready_o,
  output logic                    out_valid_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPrep = 5'b00010,
    StDiv  = 5'b00100,
    StFin  = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_fire_i) state_d = StPrep;
      StPrep: state_d = StDiv;
      StDiv:  if (sts_i.div_done) state_d = StFin;
      StFin:  state_d = StEmit;
      StEmit: if (out_ready_i && sts_i.last_part) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StEmit);
  assign cmd_o.load     = in_fire_i;
  assign cmd_o.prep     = (state_q == StPrep);
  assign cmd_o.div_step = (state_q == StDiv);
  assign cmd_o.finish   = (state_q == StFin);
  assign cmd_o.emit     = (state_q == StEmit) && out_ready_i;

endmodule
`default_nettype wire

// ===== hdl/fwst_dp.sv =====
// Datapath: channel tallies, ratio queues, bit-serial divider, part emitter.
`default_nettype none
module fwst_dp #(
  parameter int unsigned NumChannels    = fwst_pkg::NumChannels,
  parameter int unsigned RatioFifoDepth = fwst_pkg::RatioFifoDepth,
  parameter int unsigned MaxParts       = fwst_pkg::MaxParts
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fwst_pkg::dp_cmd_t  cmd_i,
  input  wire fwst_pkg::in_item_t item_i,
  input  wire logic               en_i,
  input  wire logic [8:0]         cur_w_i,
  input  wire logic [8:0]         tgt_w_i,
  output fwst_pkg::dp_sts_t       sts_o,
  output fwst_pkg::out_item_t     res_o
);

  localparam int unsigned ChW   = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int unsigned PtrW  = (RatioFifoDepth > 1) ? $clog2(RatioFifoDepth) : 1;
  localparam int unsigned CntW  = $clog2(RatioFifoDepth + 1);
  localparam int unsigned AddrW = (NumChannels * RatioFifoDepth > 1) ?
                                  $clog2(NumChannels * RatioFifoDepth) : 1;
  localparam int unsigned Limit = (MaxParts < 16) ? MaxParts : 16;
  localparam int unsigned DivW  = 17;  // dividend width: up to 256*511

  // Per channel state; valid reset via flip-flops (small depth)
  logic [11:0]     bytes_q   [NumChannels];
  logic [7:0]      flits_q   [NumChannels];
  logic [7:0]      credits_q [NumChannels];
  logic [CntW-1:0] fcnt_q    [NumChannels];
  logic [PtrW-1:0] fhead_q   [NumChannels];
  logic [7:0]      fifo_mem  [NumChannels*RatioFifoDepth];

  // Captured item
  fwst_pkg::in_item_t it_q;
  logic [ChW-1:0]  ch_q;
  logic [11:0]     bs_q;
  logic [7:0]      fc_q;
  logic [7:0]      cg_q;
  logic [CntW-1:0] cnt_q;
  logic [PtrW-1:0] head_q;
  logic [7:0]      front_q;
  logic [8:0]      cw_q, tw_q;

  // Divider
  logic [DivW-1:0] num_q, quo_q;
  logic [DivW:0]   rem_q;
  logic [4:0]      dcnt_q;

  // Result
  fwst_pkg::out_item_t base_q;
  logic [4:0] total_q;
  logic [3:0] pn_q;

  logic [ChW-1:0]   ch_in;
  logic [8:0]       have;
  logic [DivW:0]    rem_sh;
  logic             tail;
  logic [AddrW-1:0] rd_addr, wr_addr;

  assign ch_in = ChW'(32'(item_i.channel) % NumChannels);
  assign tail  = (it_q.flit_kind == fwst_pkg::KindTail) ||
                 (it_q.flit_kind == fwst_pkg::KindHeadTail);
  assign have  = {1'b0, it_q.flit_index} + 9'd1;
  assign rem_sh = {rem_q[DivW-1:0], num_q[DivW-1]};

  // Queue addresses: front entry of the incoming channel, free slot of the held one
  assign rd_addr = AddrW'(32'(ch_in) * RatioFifoDepth + 32'(fhead_q[ch_in]));
  assign wr_addr = AddrW'(32'(ch_q) * RatioFifoDepth +
                          (32'(head_q) + 32'(cnt_q)) % RatioFifoDepth);

  // Capture item and read channel state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q    <= item_i;
      ch_q    <= ch_in;
      bs_q    <= bytes_q[ch_in];
      fc_q    <= flits_q[ch_in];
      cg_q    <= credits_q[ch_in];
      cnt_q   <= fcnt_q[ch_in];
      head_q  <= fhead_q[ch_in];
      front_q <= fifo_mem[rd_addr];
      cw_q    <= (cur_w_i == 9'd0) ? 9'd1 : cur_w_i;
      tw_q    <= (tgt_w_i == 9'd0) ? 9'd1 : tgt_w_i;
    end
  end

  // Dividend setup and restoring division, one bit per cycle
  logic [DivW-1:0] total_b;
  logic [DivW-1:0] avail;
  always_comb begin
    total_b = DivW'(have) * DivW'(cw_q);
    if (tail) begin
      avail = (it_q.message_bytes > bs_q) ? DivW'(it_q.message_bytes - bs_q) : '0;
      avail = (avail == '0) ? '0 : avail + DivW'(tw_q) - DivW'(1);
    end else begin
      avail = (total_b > DivW'(bs_q)) ? total_b - DivW'(bs_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      num_q  <= avail;
      quo_q  <= '0;
      rem_q  <= '0;
      dcnt_q <= 5'(DivW);
    end else if (cmd_i.div_step && dcnt_q != 5'd0) begin
      num_q  <= num_q << 1;
      dcnt_q <= dcnt_q - 5'd1;
      if (rem_sh >= (DivW+1)'(tw_q)) begin
        rem_q <= rem_sh - (DivW+1)'(tw_q);
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (dcnt_q == 5'd0);

  // Decision logic evaluated in finish step
  fwst_pkg::out_item_t r;
  logic [4:0]  parts;
  logic        wr_bytes, wr_flits, wr_cred, push, pop;
  logic [11:0] nb;
  logic [7:0]  nf, ncg, merged;
  logic [8:0]  mdiff;
  logic [1:0]  err;
  logic [12:0] nbs;
  logic [8:0]  nfs;
  logic [DivW-1:0] q;
  always_comb begin
    r = '0;
    r.out_channel = it_q.channel;
    r.last = 1'b1;
    parts = 5'd1;
    wr_bytes = 1'b0; wr_flits = 1'b0; wr_cred = 1'b0; push = 1'b0; pop = 1'b0;
    nb = '0; nf = '0; ncg = '0; err = fwst_pkg::ErrOk; merged = '0;
    nbs = '0; nfs = '0;
    mdiff = have - {1'b0, fc_q};
    q = quo_q;
    if (it_q.operation) begin
      push = (32'(cnt_q) < RatioFifoDepth);
      r.error_code = push ? fwst_pkg::ErrOk : fwst_pkg::ErrFull;
    end else if (it_q.flit_kind > fwst_pkg::KindCredit) begin
      // ignored kind
    end else if (!en_i || cw_q == tw_q) begin
      r.flit_valid = 1'b1; r.out_kind = it_q.flit_kind;
      r.part_total = 5'd1; r.merged_count = 8'd1;
    end else if (tw_q > cw_q) begin
      if (it_q.flit_kind == fwst_pkg::KindCredit) begin
        wr_cred = 1'b1; ncg = cg_q + 8'd1;
        if (cnt_q == '0) r.error_code = fwst_pkg::ErrEmpty;
        else if (ncg == front_q) begin
          pop = 1'b1; ncg = '0;
          r.flit_valid = 1'b1; r.out_kind = fwst_pkg::KindCredit;
          r.part_total = 5'd1; r.merged_count = front_q;
        end
      end else begin
        // flits merged since the last outgoing flit, saturated at 255
        if (have > {1'b0, fc_q}) merged = mdiff[8] ? 8'd255 : mdiff[7:0];
        if (tail) begin
          wr_bytes = 1'b1; wr_flits = 1'b1;
        end else if (q != '0) begin
          wr_bytes = 1'b1; wr_flits = 1'b1;
          nbs = {1'b0, bs_q} + {4'd0, tw_q};
          nb  = nbs[12] ? 12'd4095 : nbs[11:0];
          nf  = have[8] ? 8'd255 : have[7:0];
        end
        if (q > DivW'(1)) err = fwst_pkg::ErrClamped;
        r.error_code = err;
        if (q != '0) begin
          r.flit_valid = 1'b1; r.out_kind = it_q.flit_kind; r.part_total = 5'd1;
          r.merged_count = merged; r.notice_valid = 1'b1; r.notice_count = merged;
        end
      end
    end else begin
      if (it_q.flit_kind == fwst_pkg::KindCredit) begin
        if (cnt_q == '0) begin
          err = fwst_pkg::ErrEmpty; q = '0;
        end else begin
          q = DivW'(front_q); pop = 1'b1;
        end
      end else if (tail) begin
        wr_bytes = 1'b1; wr_flits = 1'b1;
      end
      if (q > DivW'(Limit)) begin
        parts = 5'(Limit); err = fwst_pkg::ErrClamped;
      end else begin
        parts = 5'(q);
      end
      if (it_q.flit_kind != fwst_pkg::KindCredit && !tail && parts != 5'd0) begin
        wr_bytes = 1'b1; wr_flits = 1'b1;
        nbs = {1'b0, bs_q} + 13'(parts) * 13'(tw_q);
        nfs = {1'b0, fc_q} + {4'd0, parts};
        nb  = (nbs > 13'd4095) ? 12'd4095 : nbs[11:0];
        nf  = nfs[8] ? 8'd255 : nfs[7:0];
      end
      r.error_code = err;
      if (parts != 5'd0) begin
        r.flit_valid = 1'b1; r.out_kind = it_q.flit_kind;
        r.part_total = parts; r.merged_count = 8'd1;
        r.notice_valid = (it_q.flit_kind != fwst_pkg::KindCredit);
        r.notice_count = r.notice_valid ? 8'(parts) : 8'd0;
      end else begin
        parts = 5'd1;
      end
    end
  end

  // State write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        bytes_q[i] <= '0; flits_q[i] <= '0; credits_q[i] <= '0;
        fcnt_q[i] <= '0; fhead_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      if (wr_bytes) bytes_q[ch_q] <= nb;
      if (wr_flits) flits_q[ch_q] <= nf;
      if (wr_cred)  credits_q[ch_q] <= ncg;
      if (push) fcnt_q[ch_q] <= cnt_q + CntW'(1);
      if (pop) begin
        fcnt_q[ch_q]  <= cnt_q - CntW'(1);
        fhead_q[ch_q] <= PtrW'((32'(head_q) + 1) % RatioFifoDepth);
      end
    end
  end

  // Ratio queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && push)
      fifo_mem[wr_addr] <= (it_q.ratio_value == 8'd0) ? 8'd1 : it_q.ratio_value;
  end

  // Part emitter
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      base_q  <= r;
      total_q <= parts;
      pn_q    <= '0;
    end else if (cmd_i.emit) begin
      pn_q <= pn_q + 4'd1;
    end
  end

  logic fin;
  assign fin = ({1'b0, pn_q} + 5'd1 == total_q);
  assign sts_o.last_part = fin;
  always_comb begin
    res_o = base_q;
    if (base_q.flit_valid) res_o.part_number = pn_q;
    res_o.last = fin;
    if (!fin) begin
      res_o.notice_valid = 1'b0;
      res_o.notice_count = '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fwst_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`default_nettype none
module fwst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  // One item at a time: no input taken while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept during output");
  // A status result is always the final one
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast) else $error("status not last");
  // Notice only on final result
  a_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tlast) else $error("notice early");
  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind flit_width_serdes_tracker_top fwst_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
`default_nettype wire
